[rtl/tgc_pkg.sv]
// Shared types and constants of the touch gesture classifier.
`timescale 1ns / 1ps

package tgc_pkg;

  localparam int CoordBits  = 16;
  localparam int FieldW     = 16;
  localparam int MaxResults = 5;
  localparam int CntW       = 3;
  localparam logic [FieldW-1:0] ThreshReset = 16'd5;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PRESS     = 3'd1,
    ST_HOLD      = 3'd2,
    ST_LONG      = 3'd3,
    ST_MOVE      = 3'd4,
    ST_MOVE_LONG = 3'd5
  } tgc_state_e;

  typedef enum logic [2:0] {
    EV_DOWN        = 3'd0,
    EV_UP          = 3'd1,
    EV_LT_HOLD     = 3'd2,
    EV_MOVE        = 3'd3,
    EV_LONGTAP     = 3'd4,
    EV_REPEAT      = 3'd5,
    EV_REPEAT_HOLD = 3'd6,
    EV_OTHER       = 3'd7
  } tgc_event_e;

  typedef enum logic [3:0] {
    ACT_PRESS       = 4'd0,
    ACT_REFRESH     = 4'd1,
    ACT_SINGLE      = 4'd2,
    ACT_LONG        = 4'd3,
    ACT_LONG_REL    = 4'd4,
    ACT_MOVE_RIGHT  = 4'd5,
    ACT_MOVE_LEFT   = 4'd6,
    ACT_MOVE_DOWN   = 4'd7,
    ACT_MOVE_UP     = 4'd8,
    ACT_LMOVE_RIGHT = 4'd9,
    ACT_LMOVE_LEFT  = 4'd10,
    ACT_LMOVE_DOWN  = 4'd11,
    ACT_LMOVE_UP    = 4'd12,
    ACT_MOVE_REL    = 4'd13,
    ACT_HANG_END    = 4'd14,
    ACT_FLAT_END    = 4'd15
  } tgc_action_e;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } tgc_dir_e;

  typedef struct packed {
    tgc_action_e       action;
    logic [FieldW-1:0] x;
    logic [FieldW-1:0] y;
    logic              last;
  } tgc_result_t;

  typedef struct packed {
    tgc_result_t [MaxResults-1:0] ent;
    logic [CntW-1:0]              cnt;
  } tgc_batch_t;

endpackage

[rtl/tgc_core.sv]
// Gesture state machine: holds gesture state and builds the result list of one event.
`timescale 1ns / 1ps

module tgc_core #(
  parameter int COORD_BITS = tgc_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  tgc_pkg::tgc_event_e         event_i,
  input  logic [tgc_pkg::FieldW-1:0]  x_i,
  input  logic [tgc_pkg::FieldW-1:0]  y_i,
  input  logic [tgc_pkg::FieldW-1:0]  thresh_i,
  output tgc_pkg::tgc_batch_t         batch_o
);
  import tgc_pkg::*;

  localparam logic [COORD_BITS-1:0] PrevReset = {{(COORD_BITS-1){1'b1}}, 1'b0};

  tgc_state_e            state_q, state_d;
  logic [COORD_BITS-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;

  logic [COORD_BITS-1:0] xc, yc, dpx, dpy, dsx, dsy;
  logic [FieldW-1:0]     x16, y16;
  logic                  move_kind, moved, horiz;

  function automatic tgc_result_t mk(tgc_action_e act, logic [FieldW-1:0] x,
                                     logic [FieldW-1:0] y);
    tgc_result_t r;
    r.action = act;
    r.x      = x;
    r.y      = y;
    r.last   = 1'b0;
    return r;
  endfunction

  assign xc  = x_i[COORD_BITS-1:0];
  assign yc  = y_i[COORD_BITS-1:0];
  assign x16 = FieldW'(xc);
  assign y16 = FieldW'(yc);

  assign dpx = (prev_x_q > xc) ? prev_x_q - xc : xc - prev_x_q;
  assign dpy = (prev_y_q > yc) ? prev_y_q - yc : yc - prev_y_q;
  assign dsx = (start_x_q > xc) ? start_x_q - xc : xc - start_x_q;
  assign dsy = (start_y_q > yc) ? start_y_q - yc : yc - start_y_q;

  always_comb begin
    case (event_i)
      EV_MOVE, EV_LONGTAP, EV_REPEAT, EV_REPEAT_HOLD: move_kind = 1'b1;
      default: move_kind = 1'b0;
    endcase
  end

  assign moved = move_kind && ((FieldW'(dpx) > thresh_i) || (FieldW'(dpy) > thresh_i));
  assign horiz = dsx > dsy;

  // Next state
  always_comb begin
    state_d   = state_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    case (state_q)
      ST_IDLE: begin
        if (event_i == EV_DOWN) state_d = ST_PRESS;
      end
      ST_PRESS: begin
        if (event_i == EV_UP) state_d = ST_IDLE;
        else if (event_i == EV_LT_HOLD) state_d = ST_HOLD;
        else if (event_i == EV_MOVE) state_d = ST_MOVE;
      end
      ST_HOLD: begin
        if (event_i == EV_UP) begin
          state_d = ST_IDLE;
        end else if (event_i == EV_MOVE) begin
          state_d   = ST_MOVE;
          start_x_d = xc;
          start_y_d = yc;
          prev_x_d  = xc;
          prev_y_d  = yc;
        end else if (event_i == EV_REPEAT) begin
          state_d = ST_LONG;
        end
      end
      ST_LONG: begin
        if (event_i == EV_UP) begin
          state_d = ST_IDLE;
        end else if (event_i == EV_MOVE) begin
          state_d   = ST_MOVE_LONG;
          start_x_d = xc;
          start_y_d = yc;
          prev_x_d  = xc;
          prev_y_d  = yc;
        end
      end
      ST_MOVE, ST_MOVE_LONG: begin
        if (moved) begin
          prev_x_d = xc;
          prev_y_d = yc;
        end else if (event_i == EV_UP) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // Result list
  always_comb begin
    logic [CntW-1:0] n;
    tgc_dir_e        dir;
    n       = '0;
    dir     = DIR_NONE;
    batch_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (event_i == EV_DOWN) begin
          batch_o.ent[n] = mk(ACT_PRESS, x16, y16);
          n = n + CntW'(1);
        end
      end
      ST_PRESS: begin
        if (event_i == EV_MOVE) begin
          batch_o.ent[n] = mk(ACT_REFRESH, x16, y16);
          n = n + CntW'(1);
        end
      end
      ST_HOLD: begin
        if (event_i == EV_UP) begin
          batch_o.ent[n] = mk(ACT_SINGLE, x16, y16);
          n = n + CntW'(1);
        end else if (event_i == EV_MOVE) begin
          batch_o.ent[n] = mk(ACT_REFRESH, x16, y16);
          n = n + CntW'(1);
        end else if (event_i == EV_REPEAT) begin
          batch_o.ent[n] = mk(ACT_LONG, x16, y16);
          n = n + CntW'(1);
        end
      end
      ST_LONG: begin
        if (event_i == EV_UP) begin
          batch_o.ent[n] = mk(ACT_LONG_REL, x16, y16);
          n = n + CntW'(1);
        end else if (event_i == EV_MOVE) begin
          batch_o.ent[n] = mk(ACT_REFRESH, x16, y16);
          n = n + CntW'(1);
        end
      end
      ST_MOVE: begin
        if (moved) begin
          batch_o.ent[n] = mk(ACT_REFRESH, x16, y16);
          n = n + CntW'(1);
        end else if (event_i == EV_UP) begin
          if (horiz) begin
            if (xc < start_x_q) begin
              batch_o.ent[n] = mk(ACT_MOVE_RIGHT, x16, y16);
              dir = DIR_RIGHT;
            end else begin
              batch_o.ent[n] = mk(ACT_MOVE_LEFT, x16, y16);
              dir = DIR_LEFT;
            end
          end else begin
            if (yc < start_y_q) begin
              batch_o.ent[n] = mk(ACT_MOVE_DOWN, x16, y16);
              dir = DIR_DOWN;
            end else begin
              batch_o.ent[n] = mk(ACT_MOVE_UP, x16, y16);
              dir = DIR_UP;
            end
          end
          n = n + CntW'(1);
          batch_o.ent[n] = mk(ACT_REFRESH, x16, y16);
          n = n + CntW'(1);
          batch_o.ent[n] = mk(ACT_MOVE_REL, x16, y16);
          n = n + CntW'(1);
        end
      end
      ST_MOVE_LONG: begin
        if (moved) begin
          batch_o.ent[n] = mk(ACT_REFRESH, x16, y16);
          n = n + CntW'(1);
        end else if (event_i == EV_UP) begin
          batch_o.ent[n] = mk(ACT_MOVE_REL, x16, y16);
          n = n + CntW'(1);
          // Long move: down when y grew, opposite sense of the short move
          if (horiz) begin
            if (xc < start_x_q) batch_o.ent[n] = mk(ACT_LMOVE_RIGHT, x16, y16);
            else batch_o.ent[n] = mk(ACT_LMOVE_LEFT, x16, y16);
          end else begin
            if (yc > start_y_q) batch_o.ent[n] = mk(ACT_LMOVE_DOWN, x16, y16);
            else batch_o.ent[n] = mk(ACT_LMOVE_UP, x16, y16);
          end
          n = n + CntW'(1);
        end
      end
      default: begin
        n = '0;
      end
    endcase
    if (event_i == EV_UP) begin
      if (dir != DIR_NONE) begin
        batch_o.ent[n] = mk(ACT_HANG_END, FieldW'(dir), y16);
        n = n + CntW'(1);
      end
      batch_o.ent[n] = mk(ACT_FLAT_END, x16, y16);
      n = n + CntW'(1);
    end
    if (n != '0) batch_o.ent[n - CntW'(1)].last = 1'b1;
    batch_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_x_q <= '0;
      start_y_q <= '0;
      prev_x_q  <= PrevReset;
      prev_y_q  <= PrevReset;
    end else if (accept_i) begin
      state_q   <= state_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_up_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && event_i == EV_UP) |=> (state_q == ST_IDLE))
    else $error("gesture state not idle after up");
  a_up_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_i == EV_UP) |-> (batch_o.cnt != '0 &&
      batch_o.ent[batch_o.cnt - CntW'(1)].action == ACT_FLAT_END))
    else $error("up event without closing flatten end");
  a_state_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= ST_MOVE_LONG)
    else $error("gesture state left the defined range");
`endif

endmodule

[rtl/touch_gesture_classifier.sv]
// Top level of the touch gesture classifier: config register, result queue, output register.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one raw touch event with
//   its x,y coordinate. Output channel (out_valid_o / out_stall_i) carries one
//   gesture action per item; last_o marks the final action of an event.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the move step threshold;
//   it is always ready and should only be written while the block is idle.
// Output: an accepted event's actions go into the result queue, then one at
//   a time into the output register, one per cycle while out_stall_i is low.
// Throughput: a new event is taken only while the queue is empty or hands
//   over its last action, so an event with several actions (up to 5, for a
//   short-move release) holds off the next one while the queue drains into
//   the output register, one action per cycle while out_stall_i is low.
//   Events that produce no action are taken every cycle while the queue is empty.
// Reset: gesture state returns to idle, start point to zero, the last
//   reported point to all ones but the LSB, threshold to 5, queue empty.
// Stall: while out_stall_i is high the output register holds; the queue
//   behind it holds and in_stall_o rises once the queue cannot empty.
module touch_gesture_classifier #(
  parameter int COORD_BITS = tgc_pkg::CoordBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tgc_pkg::FieldW-1:0] cfg_data_i,
  // event input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 touch_event_i,
  input  logic [tgc_pkg::FieldW-1:0] touch_x_i,
  input  logic [tgc_pkg::FieldW-1:0] touch_y_i,
  // action output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 action_o,
  output logic [tgc_pkg::FieldW-1:0] out_x_o,
  output logic [tgc_pkg::FieldW-1:0] out_y_o,
  output logic                       last_o
);
  import tgc_pkg::*;

  logic [FieldW-1:0] thresh_q;

  tgc_batch_t                   batch;
  tgc_result_t [MaxResults-1:0] pend_q, pend_d;
  logic [CntW-1:0]              pend_cnt_q, pend_cnt_d;
  tgc_result_t                  out_q;
  logic                         out_valid_q, out_valid_d;
  logic                         in_acc, pop;

  // Threshold register: always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // Advance the queue head whenever the output register is free or being taken
  assign pop        = (pend_cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((pend_cnt_q == '0) || ((pend_cnt_q == CntW'(1)) && pop));
  assign in_acc     = in_valid_i && !in_stall_o;

  tgc_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .event_i (tgc_event_e'(touch_event_i)),
    .x_i     (touch_x_i),
    .y_i     (touch_y_i),
    .thresh_i(thresh_q),
    .batch_o (batch)
  );

  // Result queue: load a fresh list on accept, else shift out the head
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    if (in_acc) begin
      pend_d     = batch.ent;
      pend_cnt_d = batch.cnt;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        pend_d[i] = pend_q[i+1];
      end
      pend_cnt_d = pend_cnt_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_cnt_q  <= pend_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (pop) out_q <= pend_q[0];
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = out_q.action;
  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign last_o      = out_q.last;

`ifndef NO_ASSERTIONS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= CntW'(MaxResults))
    else $error("result queue overfilled");
  a_single_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q == CntW'(1)) |-> pend_q[0].last)
    else $error("queue tail lacks last mark");
  a_head_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q > CntW'(1)) |-> !pend_q[0].last)
    else $error("last mark ahead of queued items");
  a_flat_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == ACT_FLAT_END) |-> out_q.last)
    else $error("flatten end not marked last");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for the touch gesture classifier.
`timescale 1ns / 1ps

module tb;
  import tgc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int SettleTicks = 8;   // margin after the last pending action is taken

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_valid_q = 1'b0;
  logic [15:0] cfg_data_q  = '0;
  logic        in_valid_q  = 1'b0;
  logic [2:0]  ev_q        = '0;
  logic [15:0] x_q         = '0;
  logic [15:0] y_q         = '0;
  logic        out_stall_q = 1'b0;
  logic        gaps_on     = 1'b1;

  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [3:0]  action_o;
  logic [15:0] out_x_o;
  logic [15:0] out_y_o;
  logic        last_o;

  // gesture tracker: mirrors the block's state and threshold register
  tgc_state_e  gest_state   = ST_IDLE;
  logic [15:0] move_org_x   = '0;
  logic [15:0] move_org_y   = '0;
  logic [15:0] last_rep_x   = 16'd65534;
  logic [15:0] last_rep_y   = 16'd65534;
  logic [15:0] step_thresh  = ThreshReset;

  tgc_result_t expected_actions[$];
  tgc_result_t seen_action;
  tgc_result_t want_action;
  int          mismatches  = 0;
  int          events_sent = 0;
  int          cycle_cnt   = 0;

  touch_gesture_classifier u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid_q),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_q),
    .in_valid_i    (in_valid_q),
    .in_stall_o    (in_stall_o),
    .touch_event_i (ev_q),
    .touch_x_i     (x_q),
    .touch_y_i     (y_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_q),
    .action_o      (action_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side now and then, unless the quiet stretch is running.
  always @(posedge clk) begin
    out_stall_q <= gaps_on && ($urandom_range(0, 99) < 9);
  end

  function automatic logic [15:0] axis_gap(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic tgc_result_t make_action(tgc_action_e act, logic [15:0] x,
                                              logic [15:0] y);
    tgc_result_t r;
    r.action = act;
    r.x      = x;
    r.y      = y;
    r.last   = 1'b0;
    return r;
  endfunction

  // Advance the gesture tracker by one event and queue the actions it causes.
  function automatic void classify_event(tgc_event_e ev, logic [15:0] x, logic [15:0] y);
    tgc_result_t batch[$];
    tgc_dir_e    dir;
    logic        far;
    logic        horiz;
    dir   = DIR_NONE;
    // step check uses the last reported point before any update below
    far   = (ev inside {EV_MOVE, EV_LONGTAP, EV_REPEAT, EV_REPEAT_HOLD}) &&
            (axis_gap(last_rep_x, x) > step_thresh || axis_gap(last_rep_y, y) > step_thresh);
    horiz = axis_gap(move_org_x, x) > axis_gap(move_org_y, y);
    case (gest_state)
      ST_IDLE: begin
        if (ev == EV_DOWN) begin
          gest_state = ST_PRESS;
          batch.push_back(make_action(ACT_PRESS, x, y));
        end
      end
      ST_PRESS: begin
        if (ev == EV_UP) begin
          gest_state = ST_IDLE;
        end else if (ev == EV_LT_HOLD) begin
          gest_state = ST_HOLD;
        end else if (ev == EV_MOVE) begin
          // move start point is left as it was
          gest_state = ST_MOVE;
          batch.push_back(make_action(ACT_REFRESH, x, y));
        end
      end
      ST_HOLD: begin
        if (ev == EV_UP) begin
          gest_state = ST_IDLE;
          batch.push_back(make_action(ACT_SINGLE, x, y));
        end else if (ev == EV_MOVE) begin
          move_org_x = x; move_org_y = y;
          last_rep_x = x; last_rep_y = y;
          gest_state = ST_MOVE;
          batch.push_back(make_action(ACT_REFRESH, x, y));
        end else if (ev == EV_REPEAT) begin
          gest_state = ST_LONG;
          batch.push_back(make_action(ACT_LONG, x, y));
        end
      end
      ST_LONG: begin
        if (ev == EV_UP) begin
          gest_state = ST_IDLE;
          batch.push_back(make_action(ACT_LONG_REL, x, y));
        end else if (ev == EV_MOVE) begin
          move_org_x = x; move_org_y = y;
          last_rep_x = x; last_rep_y = y;
          gest_state = ST_MOVE_LONG;
          batch.push_back(make_action(ACT_REFRESH, x, y));
        end
      end
      ST_MOVE: begin
        if (far) begin
          last_rep_x = x; last_rep_y = y;
          batch.push_back(make_action(ACT_REFRESH, x, y));
        end else if (ev == EV_UP) begin
          // tie on the axes falls to the vertical branch
          if (horiz && x < move_org_x) begin
            batch.push_back(make_action(ACT_MOVE_RIGHT, x, y)); dir = DIR_RIGHT;
          end else if (horiz) begin
            batch.push_back(make_action(ACT_MOVE_LEFT, x, y));  dir = DIR_LEFT;
          end else if (y < move_org_y) begin
            batch.push_back(make_action(ACT_MOVE_DOWN, x, y));  dir = DIR_DOWN;
          end else begin
            batch.push_back(make_action(ACT_MOVE_UP, x, y));    dir = DIR_UP;
          end
          gest_state = ST_IDLE;
          batch.push_back(make_action(ACT_REFRESH, x, y));
          batch.push_back(make_action(ACT_MOVE_REL, x, y));
        end
      end
      ST_MOVE_LONG: begin
        if (far) begin
          last_rep_x = x; last_rep_y = y;
          batch.push_back(make_action(ACT_REFRESH, x, y));
        end else if (ev == EV_UP) begin
          batch.push_back(make_action(ACT_MOVE_REL, x, y));
          // vertical sense is flipped against the short move
          if (horiz && x < move_org_x)  batch.push_back(make_action(ACT_LMOVE_RIGHT, x, y));
          else if (horiz)               batch.push_back(make_action(ACT_LMOVE_LEFT, x, y));
          else if (y > move_org_y)      batch.push_back(make_action(ACT_LMOVE_DOWN, x, y));
          else                          batch.push_back(make_action(ACT_LMOVE_UP, x, y));
          gest_state = ST_IDLE;
        end
      end
      default: ;
    endcase
    if (ev == EV_UP) begin
      if (dir != DIR_NONE) batch.push_back(make_action(ACT_HANG_END, 16'(dir), y));
      batch.push_back(make_action(ACT_FLAT_END, x, y));
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_actions.push_back(batch[i]);
  endfunction

  // Check each accepted action against the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall_q) begin
      seen_action.action = tgc_action_e'(action_o);
      seen_action.x      = out_x_o;
      seen_action.y      = out_y_o;
      seen_action.last   = last_o;
      if (expected_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected action %0d x=%0d y=%0d last=%0b",
                   action_o, out_x_o, out_y_o, last_o);
      end else begin
        want_action = expected_actions.pop_front();
        if (seen_action.action !== want_action.action || seen_action.x !== want_action.x ||
            seen_action.y !== want_action.y || seen_action.last !== want_action.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp act=%0d x=%0d y=%0d last=%0b, got act=%0d x=%0d y=%0d last=%0b",
                     want_action.action, want_action.x, want_action.y, want_action.last,
                     action_o, out_x_o, out_y_o, last_o);
        end
      end
    end
  end

  // Send one event item; starts and returns just after a rising edge.
  task automatic push_touch(tgc_event_e ev, logic [15:0] x, logic [15:0] y);
    while (gaps_on && $urandom_range(0, 99) < 9) begin
      in_valid_q <= 1'b0;
      @(posedge clk);
    end
    in_valid_q <= 1'b1;
    ev_q       <= ev;
    x_q        <= x;
    y_q        <= y;
    do @(posedge clk); while (in_stall_o);
    classify_event(ev, x, y);
    events_sent++;
  endtask

  // Hold off input until every pending action has drained.
  task automatic wait_idle();
    in_valid_q <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    wait_idle();
    cfg_valid_q <= 1'b1;
    cfg_data_q  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_q <= 1'b0;
    step_thresh = value;
  endtask

  function automatic logic [15:0] nudge(logic [15:0] c);
    logic [15:0] d;
    d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    return $urandom_range(0, 1) ? c + d : c - d;
  endfunction

  // Drag the point through a few step events of any moving kind.
  task automatic send_moves(inout logic [15:0] cx, inout logic [15:0] cy);
    int n;
    n = $urandom_range(0, 5);
    repeat (n) begin
      cx = nudge(cx);
      cy = nudge(cy);
      push_touch(tgc_event_e'($urandom_range(EV_MOVE, EV_REPEAT_HOLD)), cx, cy);
    end
  endtask

  // One gesture: mostly well-formed sequences, some pure noise.
  task automatic send_gesture();
    logic [15:0] ox, oy, cx, cy, d;
    int          kind;
    kind = $urandom_range(0, 9);
    ox   = 16'($urandom);
    oy   = 16'($urandom);
    cx   = ox;
    cy   = oy;
    if (kind == 9) begin
      repeat ($urandom_range(1, 3))
        push_touch(tgc_event_e'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
    end else begin
      push_touch(EV_DOWN, ox, oy);
      if (kind inside {[1:6]}) push_touch(EV_LT_HOLD, cx, cy);
      if (kind == 2 || kind inside {[5:6]}) push_touch(EV_REPEAT, cx, cy);
      if (kind >= 3) begin
        cx = nudge(cx);
        cy = nudge(cy);
        if (kind <= 6) begin
          ox = cx;
          oy = cy;
        end
        push_touch(EV_MOVE, cx, cy);
        send_moves(cx, cy);
      end
      // now and then release with equal axis offsets
      d = 16'($urandom_range(0, 300));
      if ($urandom_range(0, 5) == 0) push_touch(EV_UP, ox + d, oy - d);
      else                           push_touch(EV_UP, nudge(cx), nudge(cy));
    end
  endtask

  task automatic test_gestures(int count);
    int target;
    target = events_sent + count;
    while (events_sent < target) send_gesture();
  endtask

  // Walk every transition once, with the threshold at its reset value.
  task automatic test_directed();
    push_touch(EV_UP, 16'd0, 16'd0);                 // up while idle: flatten end only
    push_touch(EV_OTHER, 16'hFFFF, 16'hFFFF);        // ignored
    push_touch(EV_DOWN, 16'd100, 16'd200);
    push_touch(EV_UP, 16'd100, 16'd200);             // plain tap
    push_touch(EV_DOWN, 16'd1, 16'd2);
    push_touch(EV_LT_HOLD, 16'd1, 16'd2);
    push_touch(EV_UP, 16'hFFFF, 16'd0);              // single
    push_touch(EV_DOWN, 16'd10, 16'd10);
    push_touch(EV_LT_HOLD, 16'd10, 16'd10);
    push_touch(EV_REPEAT, 16'd10, 16'd10);           // long
    push_touch(EV_UP, 16'd10, 16'd10);               // long release
    push_touch(EV_DOWN, 16'd1000, 16'd1000);
    push_touch(EV_LT_HOLD, 16'd1000, 16'd1000);
    push_touch(EV_MOVE, 16'd1000, 16'd1000);         // sets the move start
    push_touch(EV_MOVE, 16'd1003, 16'd1002);         // within the step: dropped
    push_touch(EV_REPEAT_HOLD, 16'd1010, 16'd1000);  // beyond the step: refresh
    push_touch(EV_UP, 16'd0, 16'd1000);              // swipe with hang end, five actions
    push_touch(EV_DOWN, 16'd500, 16'd500);
    push_touch(EV_LT_HOLD, 16'd500, 16'd500);
    push_touch(EV_REPEAT, 16'd500, 16'd500);
    push_touch(EV_MOVE, 16'd500, 16'd500);
    push_touch(EV_LONGTAP, 16'd500, 16'hFFFF);
    push_touch(EV_UP, 16'd500, 16'hFFFF);            // long move down
    push_touch(EV_DOWN, 16'd7, 16'd7);
    push_touch(EV_MOVE, 16'd9, 16'd9);               // press then move keeps old start
    push_touch(EV_UP, 16'd500, 16'd500);             // axis tie on release
  endtask

  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    test_gestures(25);
    write_threshold(16'hFFFF);
    test_gestures(20);
  endtask

  // Run with no idling on either side at a random small threshold (1 to 40).
  task automatic test_back_to_back();
    write_threshold(16'($urandom_range(1, 40)));
    gaps_on <= 1'b0;
    test_gestures(25);
    wait_idle();
    gaps_on <= 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_gestures(20);
    test_threshold_extremes();
    test_back_to_back();
    wait_idle();
    if (mismatches == 0 && expected_actions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
